@@ rtl/mpsf_pkg.sv @@
// ----------------------------------------------------------------------------
// mpsf_pkg
// Shared types and constants of the multi-pattern substring filter.
// ----------------------------------------------------------------------------
package mpsf_pkg;

  localparam int CFG_W = 10;

  typedef enum logic [1:0] {
    CMD_SCAN    = 2'd0,
    CMD_WR_BYTE = 2'd1,
    CMD_SET_LEN = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_in;
    logic [8:0] entry_index;
    logic [3:0] entry_pos;
    logic [4:0] entry_len;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic blocked;
    logic match_now;
    logic last_out;
  } out_word_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

@@ rtl/mpsf_ram.sv @@
// ----------------------------------------------------------------------------
// mpsf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mpsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/mpsf_cell.sv @@
// ----------------------------------------------------------------------------
// mpsf_cell
// One window cell: holds one recent byte and its fill bit, passes them on to
// the next cell on a scan, and compares its byte with the pattern byte that
// lines up with it for the current pattern length.
// ----------------------------------------------------------------------------
module mpsf_cell #(
  parameter int K               = 0,
  parameter int MAX_PATTERN_LEN = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  mpsf_pkg::cell_ctrl_t                       ctrl,
  input  logic [7:0]                                 byte_in,
  input  logic                                       vld_in,
  output logic [7:0]                                 byte_out,
  output logic                                       vld_out,
  input  logic [MAX_PATTERN_LEN-1:0][7:0]            pat_row,
  input  logic [$clog2(MAX_PATTERN_LEN + 1)-1:0]     pat_len,
  output logic                                       ok
);

  localparam int PW = $clog2(MAX_PATTERN_LEN);

  logic [7:0]    byte_r;
  logic          vld_r;
  logic [PW-1:0] sel_idx;
  logic          used;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
      vld_r  <= 1'b0;
    end else if (ctrl.clear) begin
      byte_r <= '0;
      vld_r  <= 1'b0;
    end else if (ctrl.shift) begin
      byte_r <= byte_in;
      vld_r  <= vld_in;
    end
  end

  // pattern byte len-1-K faces this cell
  assign sel_idx  = PW'(32'(pat_len) - 32'(K) - 32'd1);
  assign used     = (32'(pat_len) > 32'(K));
  assign ok       = !used || (vld_r && (byte_r == pat_row[sel_idx]));
  assign byte_out = byte_r;
  assign vld_out  = vld_r;

endmodule

@@ rtl/multi_pattern_substring_filter.sv @@
// ----------------------------------------------------------------------------
// multi_pattern_substring_filter
// Case-insensitive multi-pattern substring filter over a byte stream, with a
// pattern table loaded through write words.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | word
//   in_     | input     | in_valid / in_stall | in_word_t: cmd, byte, entry, len, last
//   out_    | output    | out_valid/out_stall | out_word_t: blocked, match_now, last_out
//   cfg_    | input     | cfg_valid/cfg_ready | active_patterns, 10 bits
//
// A scan byte reads N = min(active_patterns, NUM_PATTERNS) table entries, one
// table entry per cycle from the pattern RAMs, and checks each with the window
// cells; no new word is taken until the result has gone to the output register.
// A write word skips the scan. Reset clears the window, the sticky flag and the
// register; the pattern table is not cleared. A stalled result holds in the output
// register while the next word is taken and worked on.
// ----------------------------------------------------------------------------
module multi_pattern_substring_filter #(
  parameter int NUM_PATTERNS    = 512,
  parameter int MAX_PATTERN_LEN = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mpsf_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mpsf_pkg::out_word_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mpsf_pkg::CFG_W-1:0]    cfg_data
);

  localparam int AW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int CW = $clog2(NUM_PATTERNS + 1);
  localparam int LW = $clog2(MAX_PATTERN_LEN + 1);

  mpsf_pkg::state_t               state_r, state_nxt;
  logic [mpsf_pkg::CFG_W-1:0]     act_r;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic                           rd_vld_r, rd_vld_nxt;
  logic                           hit_r, hit_nxt;
  logic                           scan_r, scan_nxt;
  logic                           last_r, last_nxt;
  logic                           blocked_r, blocked_nxt;
  logic                           out_valid_r, out_valid_nxt;
  mpsf_pkg::out_word_t            out_data_r, out_data_nxt;
  mpsf_pkg::out_word_t            res;

  logic                           in_acc;
  logic                           is_scan;
  logic                           idx_ok;
  logic                           pos_ok;
  logic [7:0]                     char_fold;
  logic [LW-1:0]                  len_sat;
  logic [CW-1:0]                  num_act;
  logic [AW-1:0]                  wr_addr;
  logic [AW-1:0]                  rd_addr;
  logic                           issue;
  logic                           scan_done;
  logic                           finish_go;
  logic                           hit_entry;
  logic                           len_we;
  logic [MAX_PATTERN_LEN-1:0]     byte_we;
  logic [MAX_PATTERN_LEN-1:0][7:0] pat_row;
  logic [LW-1:0]                  len_rd;
  mpsf_pkg::cell_ctrl_t           cell_ctrl;
  logic [MAX_PATTERN_LEN-1:0][7:0] win_byte;
  logic [MAX_PATTERN_LEN-1:0]     win_vld;
  logic [MAX_PATTERN_LEN-1:0]     ok_vec;

  assign in_stall  = (state_r != mpsf_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign is_scan   = (in_data.cmd == mpsf_pkg::CMD_SCAN);
  assign idx_ok    = (32'(in_data.entry_index) < 32'(NUM_PATTERNS));
  assign pos_ok    = (32'(in_data.entry_pos) < 32'(MAX_PATTERN_LEN));
  assign char_fold = mpsf_pkg::fold_case(in_data.char_in);
  assign len_sat   = (32'(in_data.entry_len) > 32'(MAX_PATTERN_LEN)) ?
                     LW'(MAX_PATTERN_LEN) : LW'(in_data.entry_len);
  assign num_act   = (32'(act_r) > 32'(NUM_PATTERNS)) ? CW'(NUM_PATTERNS) : CW'(act_r);
  assign wr_addr   = AW'(in_data.entry_index);
  assign rd_addr   = cnt_r[AW-1:0];
  assign issue     = (state_r == mpsf_pkg::ST_SCAN) && (cnt_r != num_act);
  assign scan_done = (cnt_r == num_act) && !rd_vld_r;
  assign finish_go = (state_r == mpsf_pkg::ST_FINISH) && (!out_valid_r || !out_stall);
  assign hit_entry = (len_rd != '0) && (&ok_vec);
  assign len_we    = in_acc && (in_data.cmd == mpsf_pkg::CMD_SET_LEN) && idx_ok;
  assign cfg_ready = 1'b1;

  // pattern table: one RAM per byte position plus one for lengths
  genvar j;
  generate
    for (j = 0; j < MAX_PATTERN_LEN; j++) begin : g_pat
      assign byte_we[j] = in_acc && (in_data.cmd == mpsf_pkg::CMD_WR_BYTE) && idx_ok &&
                          pos_ok && (32'(in_data.entry_pos) == 32'(j));
      mpsf_ram #(
        .WIDTH (8),
        .DEPTH (NUM_PATTERNS)
      ) u_byte_ram (
        .clk   (clk),
        .we    (byte_we[j]),
        .waddr (wr_addr),
        .wdata (char_fold),
        .raddr (rd_addr),
        .rdata (pat_row[j])
      );
    end
  endgenerate

  mpsf_ram #(
    .WIDTH (LW),
    .DEPTH (NUM_PATTERNS)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (wr_addr),
    .wdata (len_sat),
    .raddr (rd_addr),
    .rdata (len_rd)
  );

  // window: cell 0 holds the newest byte
  genvar k;
  generate
    for (k = 0; k < MAX_PATTERN_LEN; k++) begin : g_cell
      logic [7:0] b_in;
      logic       v_in;
      if (k == 0) begin : g_head
        assign b_in = char_fold;
        assign v_in = 1'b1;
      end else begin : g_link
        assign b_in = win_byte[k-1];
        assign v_in = win_vld[k-1];
      end
      mpsf_cell #(
        .K               (k),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cell_ctrl),
        .byte_in  (b_in),
        .vld_in   (v_in),
        .byte_out (win_byte[k]),
        .vld_out  (win_vld[k]),
        .pat_row  (pat_row),
        .pat_len  (len_rd),
        .ok       (ok_vec[k])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mpsf_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = is_scan ? mpsf_pkg::ST_SCAN : mpsf_pkg::ST_FINISH;
        end
      end
      mpsf_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = mpsf_pkg::ST_FINISH;
        end
      end
      mpsf_pkg::ST_FINISH: begin
        if (finish_go) begin
          state_nxt = mpsf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mpsf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = issue;
    hit_nxt       = hit_r;
    scan_nxt      = scan_r;
    last_nxt      = last_r;
    blocked_nxt   = blocked_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    res.blocked   = blocked_r | (scan_r & hit_r);
    res.match_now = scan_r & hit_r;
    res.last_out  = scan_r & last_r;

    cell_ctrl.shift = in_acc && is_scan;
    cell_ctrl.clear = finish_go && scan_r && last_r;

    if (in_acc) begin
      cnt_nxt  = '0;
      hit_nxt  = 1'b0;
      scan_nxt = is_scan;
      last_nxt = in_data.last;
    end
    if (issue) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (rd_vld_r && hit_entry) begin
      hit_nxt = 1'b1;
    end
    if (finish_go) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
      if (scan_r) begin
        blocked_nxt = last_r ? 1'b0 : res.blocked;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpsf_pkg::ST_IDLE;
      act_r       <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      scan_r      <= 1'b0;
      last_r      <= 1'b0;
      blocked_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      hit_r       <= hit_nxt;
      scan_r      <= scan_nxt;
      last_r      <= last_nxt;
      blocked_r   <= blocked_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        act_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/mpsf_chk.sv @@
// ----------------------------------------------------------------------------
// mpsf_chk
// Port-level checks of the substring filter, bound to the top level.
// ----------------------------------------------------------------------------
module mpsf_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input mpsf_pkg::out_word_t out_data
);

  logic blk_seen_r;

  // a taken word that says blocked inside a string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_seen_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      blk_seen_r <= out_data.blocked && !out_data.last_out;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in work");

  a_match_blk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.match_now || out_data.blocked))
    else $error("match without blocked");

  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!blk_seen_r || out_data.blocked))
    else $error("blocked dropped inside a string");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind multi_pattern_substring_filter mpsf_chk u_mpsf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
